[rtl/core/dcc_pkg.sv]
// dcc_pkg: shared types, codes and constants of the distinct colour counter.
// Used by dcc_ctrl, dcc_dp, distinct_color_counter and dcc_checker; depends on nothing.
package dcc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COLOR_W         = 32;
    localparam int COUNT_W         = 16;
    localparam int ENTRY_W         = COLOR_W + COUNT_W;
    localparam int STATUS_W        = 2;
    localparam int S_TDATA_W       = 32;
    localparam int S_TUSER_W       = 1;
    localparam int M_TDATA_W       = 48;
    localparam int M_TUSER_W       = 3;

    localparam logic [COUNT_W-1:0] THRESHOLD_RST = 16'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE     = 16'd1;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } dcc_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_RPT_SCAN
    } dcc_state_t;

    typedef enum logic [2:0] {
        OUT_HIT,
        OUT_INS,
        OUT_FULL,
        OUT_PEND_MID,
        OUT_PEND_LAST,
        OUT_EMPTY
    } dcc_out_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic         start;     // new word accepted: latch colour, rewind scan
        logic         step;      // advance scan by one entry
        logic         hit_wr;    // write back incremented count of hit entry
        logic         ins_wr;    // append colour at end of table
        logic         pend_load; // capture current entry as pending report
        logic         out_load;  // load output register
        dcc_out_sel_t out_sel;
    } dcc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // compared entry equals colour
        logic qual;      // compared entry reaches threshold
        logic more;      // entries left to read
        logic rd_vld;    // read data holds an entry under compare
        logic full;      // no free entry
        logic pend_vld;  // pending report entry held
        logic out_free;  // output register can take a word this cycle
    } dcc_stat_t;

endpackage

[rtl/core/dcc_ram.sv]
// dcc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dcc_ctrl.sv]
// dcc_ctrl: sequencer for add and report scans.
// Depends on dcc_pkg for state, command and status types.
module dcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                kind,
    output logic                s_tready,
    input  dcc_pkg::dcc_stat_t  stat,
    output dcc_pkg::dcc_cmd_t   cmd
);

    dcc_pkg::dcc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dcc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dcc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (kind == dcc_pkg::KIND_REPORT) ? dcc_pkg::S_RPT_SCAN
                                                                : dcc_pkg::S_ADD_SCAN;
                end
            end
            dcc_pkg::S_ADD_SCAN: begin
                if (stat.hit) begin
                    if (stat.out_free) state_next = dcc_pkg::S_IDLE;
                end else if (!stat.rd_vld && !stat.more && stat.out_free) begin
                    state_next = dcc_pkg::S_IDLE;
                end
            end
            dcc_pkg::S_RPT_SCAN: begin
                if (!stat.rd_vld && !stat.more && stat.out_free) begin
                    state_next = dcc_pkg::S_IDLE;
                end
            end
            default: state_next = dcc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd       = '0;
        cmd.out_sel = dcc_pkg::OUT_EMPTY;
        s_tready  = 1'b0;
        case (state_reg)
            dcc_pkg::S_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            dcc_pkg::S_ADD_SCAN: begin
                if (stat.hit) begin
                    if (stat.out_free) begin
                        cmd.hit_wr   = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = dcc_pkg::OUT_HIT;
                    end
                end else if (stat.rd_vld || stat.more) begin
                    cmd.step = 1'b1;
                end else if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.full) begin
                        cmd.out_sel = dcc_pkg::OUT_FULL;
                    end else begin
                        cmd.ins_wr  = 1'b1;
                        cmd.out_sel = dcc_pkg::OUT_INS;
                    end
                end
            end
            dcc_pkg::S_RPT_SCAN: begin
                if (stat.rd_vld || stat.more) begin
                    // a second qualifying entry needs the pending one sent first
                    if (!(stat.qual && stat.pend_vld && !stat.out_free)) begin
                        cmd.step = 1'b1;
                        if (stat.qual) begin
                            cmd.pend_load = 1'b1;
                            if (stat.pend_vld) begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = dcc_pkg::OUT_PEND_MID;
                            end
                        end
                    end
                end else if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = stat.pend_vld ? dcc_pkg::OUT_PEND_LAST
                                                 : dcc_pkg::OUT_EMPTY;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/dcc_dp.sv]
// dcc_dp: colour table, scan counter, compare, pending entry and output register.
// Depends on dcc_pkg and dcc_ram.
module dcc_dp #(
    parameter int TABLE_DEPTH = dcc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [dcc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            cfg_wr_en,
    input  logic [dcc_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  dcc_pkg::dcc_cmd_t               cmd,
    output dcc_pkg::dcc_stat_t              stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dcc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [dcc_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    logic [dcc_pkg::COUNT_W-1:0] threshold_reg;
    logic [CW-1:0]               filled_reg;
    logic [CW-1:0]               addr_reg;
    logic [AW-1:0]               cmp_idx_reg;
    logic                        rd_vld_reg;
    logic [dcc_pkg::COLOR_W-1:0] key_reg;
    logic                        pend_vld_reg;
    logic [dcc_pkg::ENTRY_W-1:0] pend_reg;

    logic                        out_vld_reg;
    logic [dcc_pkg::COLOR_W-1:0] out_key_reg;
    logic [dcc_pkg::COUNT_W-1:0] out_cnt_reg;
    logic [dcc_pkg::STATUS_W-1:0] out_status_reg;
    logic                        out_ev_reg;
    logic                        out_last_reg;

    logic                        more;
    logic                        rd_en;
    logic                        wr_en;
    logic [AW-1:0]               waddr;
    logic [dcc_pkg::ENTRY_W-1:0] wdata;
    logic [dcc_pkg::ENTRY_W-1:0] rdata;
    logic [dcc_pkg::COLOR_W-1:0] rd_key;
    logic [dcc_pkg::COUNT_W-1:0] rd_cnt;
    logic [dcc_pkg::COUNT_W-1:0] cnt_inc;

    assign rd_key  = rdata[dcc_pkg::COLOR_W-1:0];
    assign rd_cnt  = rdata[dcc_pkg::ENTRY_W-1:dcc_pkg::COLOR_W];
    assign cnt_inc = (rd_cnt == dcc_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + dcc_pkg::COUNT_ONE;
    assign more    = addr_reg < filled_reg;
    assign rd_en   = cmd.step && more;

    assign wr_en = cmd.hit_wr || cmd.ins_wr;
    assign waddr = cmd.hit_wr ? cmp_idx_reg : filled_reg[AW-1:0];
    assign wdata = cmd.hit_wr ? {cnt_inc, key_reg} : {dcc_pkg::COUNT_ONE, key_reg};

    dcc_ram #(
        .WIDTH (dcc_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= dcc_pkg::THRESHOLD_RST;
            filled_reg    <= '0;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) threshold_reg <= cfg_wr_data;
            if (cmd.ins_wr) filled_reg <= filled_reg + CW'(1);
            if (cmd.start) begin
                addr_reg     <= '0;
                rd_vld_reg   <= 1'b0;
                pend_vld_reg <= 1'b0;
            end else begin
                if (cmd.step) begin
                    rd_vld_reg <= more;
                    if (more) addr_reg <= addr_reg + CW'(1);
                end
                if (cmd.pend_load) pend_vld_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) key_reg <= s_tdata;
        if (rd_en) cmp_idx_reg <= addr_reg[AW-1:0];
        if (cmd.pend_load) pend_reg <= rdata;
        if (cmd.out_load) begin
            case (cmd.out_sel)
                dcc_pkg::OUT_HIT: begin
                    out_key_reg    <= key_reg;
                    out_cnt_reg    <= cnt_inc;
                    out_status_reg <= dcc_pkg::ST_MATCH;
                    out_ev_reg     <= 1'b1;
                    out_last_reg   <= 1'b1;
                end
                dcc_pkg::OUT_INS: begin
                    out_key_reg    <= key_reg;
                    out_cnt_reg    <= dcc_pkg::COUNT_ONE;
                    out_status_reg <= dcc_pkg::ST_INSERTED;
                    out_ev_reg     <= 1'b1;
                    out_last_reg   <= 1'b1;
                end
                dcc_pkg::OUT_FULL: begin
                    out_key_reg    <= key_reg;
                    out_cnt_reg    <= '0;
                    out_status_reg <= dcc_pkg::ST_FULL;
                    out_ev_reg     <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
                dcc_pkg::OUT_PEND_MID, dcc_pkg::OUT_PEND_LAST: begin
                    out_key_reg    <= pend_reg[dcc_pkg::COLOR_W-1:0];
                    out_cnt_reg    <= pend_reg[dcc_pkg::ENTRY_W-1:dcc_pkg::COLOR_W];
                    out_status_reg <= dcc_pkg::ST_MATCH;
                    out_ev_reg     <= 1'b1;
                    out_last_reg   <= (cmd.out_sel == dcc_pkg::OUT_PEND_LAST);
                end
                default: begin
                    out_key_reg    <= '0;
                    out_cnt_reg    <= '0;
                    out_status_reg <= dcc_pkg::ST_MATCH;
                    out_ev_reg     <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign stat.hit      = rd_vld_reg && (rd_key == key_reg);
    assign stat.qual     = rd_vld_reg && (rd_cnt >= threshold_reg);
    assign stat.more     = more;
    assign stat.rd_vld   = rd_vld_reg;
    assign stat.full     = (filled_reg == FULL_CNT);
    assign stat.pend_vld = pend_vld_reg;
    assign stat.out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_cnt_reg, out_key_reg};
    assign m_tuser  = {out_ev_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

[rtl/core/distinct_color_counter.sv]
// distinct_color_counter: top level of the distinct colour counting table.
// Depends on dcc_pkg, dcc_ctrl, dcc_dp (and dcc_ram through dcc_dp).
//
// Keeps up to TABLE_DEPTH distinct RGBA colours with 16-bit saturating counts.
// An add word (tuser kind 0) searches the table in insertion order and returns
// one word: match (count after increment), insert (count 1), or table full
// (colour echoed, count 0, entry_valid 0). A report word (kind 1) returns every
// entry whose count is at least the threshold register, in insertion order,
// tlast on the final one; with no such entry it returns one all-zero word with
// entry_valid 0 and tlast set. One word is processed at a time: the table sits
// in a RAM with one registered read port, scanned one entry per cycle while a
// report is not held by a full output register. The final result of an add or
// a report is loaded into the output register once every filled entry has
// been compared (an add that hits loads on that entry; an empty table loads
// without a read), and later while the output register waits to drain. The
// next word is taken the cycle after that load.
// No clearing pass after reset: only filled entries are ever read. Write the
// threshold only while idle.

module distinct_color_counter #(
    parameter int TABLE_DEPTH = dcc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcc_pkg::S_TDATA_W-1:0]  s_tdata,   // red, green, blue, alpha
    input  logic [dcc_pkg::S_TUSER_W-1:0]  s_tuser,   // kind
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dcc_pkg::M_TDATA_W-1:0]  m_tdata,   // out_red, out_green, out_blue,
                                                      // out_alpha, occurrences
    output logic [dcc_pkg::M_TUSER_W-1:0]  m_tuser,   // status[1:0], entry_valid
    output logic                           m_tlast,
    // threshold register
    input  logic                           cfg_wr_en,
    input  logic [dcc_pkg::COUNT_W-1:0]    cfg_wr_data
);

    dcc_pkg::dcc_cmd_t  cmd;
    dcc_pkg::dcc_stat_t stat;

    // sequencer: idle / add scan / report scan
    dcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .kind     (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table RAM, compare, pending report entry and output register
    dcc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

[rtl/core/dcc_checker.sv]
// dcc_checker: port-level assertions for distinct_color_counter, bound below.
// Depends on dcc_pkg.
module dcc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dcc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dcc_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed under stall");

    // one word in flight: not ready straight after an accept
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while scan busy");

    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == dcc_pkg::ST_FULL |->
            m_tlast && !m_tuser[2] && m_tdata[47:32] == 16'd0)
        else $error("table-full word malformed");

    a_ins_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == dcc_pkg::ST_INSERTED |->
            m_tlast && m_tuser[2] && m_tdata[47:32] == 16'd1)
        else $error("insert word malformed");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == dcc_pkg::ST_MATCH && !m_tuser[2] |->
            m_tlast && m_tdata == '0)
        else $error("empty report word malformed");

endmodule

bind distinct_color_counter dcc_checker u_dcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[test/tb_top.sv]
// tb_top: self-checking bench for distinct_color_counter over its stream ports.
// Depends on dcc_pkg and the RTL under rtl/core; reads no files.
`timescale 1ns / 100ps

module tb_top;

    localparam int TABLE_DEPTH = dcc_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = TABLE_DEPTH + 4;  // longest scan plus output slack
    localparam int PALETTE_N   = 20;

    // one input word as the block sees it
    typedef struct {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } colour_word_t;

    // one result word, field by field
    typedef struct {
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        logic [7:0]                  alpha;
        logic [dcc_pkg::COUNT_W-1:0] occ;
        dcc_pkg::dcc_status_t        status;
        logic                        valid;
        logic                        last;
    } colour_result_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [dcc_pkg::S_TDATA_W-1:0] s_tdata     = '0;   // red, green, blue, alpha
    logic [dcc_pkg::S_TUSER_W-1:0] s_tuser     = '0;   // kind
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [dcc_pkg::M_TDATA_W-1:0] m_tdata;            // out_red, out_green, out_blue,
                                                       // out_alpha, occurrences
    logic [dcc_pkg::M_TUSER_W-1:0] m_tuser;            // status[1:0], entry_valid
    logic                          m_tlast;
    logic                          cfg_wr_en   = 1'b0;
    logic [dcc_pkg::COUNT_W-1:0]   cfg_wr_data = '0;

    distinct_color_counter #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus words waiting for the driver, and results still owed by the block.
    colour_word_t   pending_words[$];
    colour_result_t awaited_results[$];

    // Shadow of the colour table and the threshold register.
    logic [31:0]                 shadow_key[TABLE_DEPTH];
    logic [dcc_pkg::COUNT_W-1:0] shadow_count[TABLE_DEPTH];
    int                          shadow_filled = 0;
    logic [dcc_pkg::COUNT_W-1:0] report_min = dcc_pkg::THRESHOLD_RST;

    bit          quiet = 1'b0;       // no idling on either side when set
    int          failures = 0;
    int          cycle_count = 0;
    int          n_matched = 0, n_inserted = 0, n_dropped = 0, n_saturated = 0;
    int          n_reports = 0, n_empty_reports = 0, n_reported = 0;
    logic [31:0] palette[PALETTE_N];

    // ---------------------------------------------------------------
    // Predictor: applies one accepted word to the shadow table and
    // queues the result words it must produce.
    // ---------------------------------------------------------------
    function automatic void tally_word(input colour_word_t w);
        logic [31:0]    key;
        colour_result_t r;
        int             slot;
        int             hits;
        int             k;

        key  = {w.red, w.green, w.blue, w.alpha};
        slot = -1;
        if (w.kind == dcc_pkg::KIND_ADD) begin
            for (int i = 0; i < shadow_filled; i++)
                if (slot < 0 && shadow_key[i] == key) slot = i;
            r.red   = w.red;
            r.green = w.green;
            r.blue  = w.blue;
            r.alpha = w.alpha;
            r.last  = 1'b1;
            if (slot >= 0) begin
                // a hit on a saturated entry leaves it at the maximum
                if (shadow_count[slot] != dcc_pkg::COUNT_MAX)
                    shadow_count[slot] = shadow_count[slot] + dcc_pkg::COUNT_ONE;
                else
                    n_saturated++;
                r.occ    = shadow_count[slot];
                r.status = dcc_pkg::ST_MATCH;
                r.valid  = 1'b1;
                n_matched++;
            end else if (shadow_filled < TABLE_DEPTH) begin
                shadow_key[shadow_filled]   = key;
                shadow_count[shadow_filled] = dcc_pkg::COUNT_ONE;
                shadow_filled++;
                r.occ    = dcc_pkg::COUNT_ONE;
                r.status = dcc_pkg::ST_INSERTED;
                r.valid  = 1'b1;
                n_inserted++;
            end else begin
                // table full: colour echoed, nothing stored
                r.occ    = '0;
                r.status = dcc_pkg::ST_FULL;
                r.valid  = 1'b0;
                n_dropped++;
            end
            awaited_results.push_back(r);
        end else begin
            n_reports++;
            hits = 0;
            for (int i = 0; i < shadow_filled; i++)
                if (shadow_count[i] >= report_min) hits++;
            if (hits == 0) begin
                // empty report: one all-zero word, no entry, last set
                r.red    = '0;
                r.green  = '0;
                r.blue   = '0;
                r.alpha  = '0;
                r.occ    = '0;
                r.status = dcc_pkg::ST_MATCH;
                r.valid  = 1'b0;
                r.last   = 1'b1;
                awaited_results.push_back(r);
                n_empty_reports++;
            end else begin
                k = 0;
                for (int i = 0; i < shadow_filled; i++) begin
                    if (shadow_count[i] >= report_min) begin
                        k++;
                        {r.red, r.green, r.blue, r.alpha} = shadow_key[i];
                        r.occ    = shadow_count[i];
                        r.status = dcc_pkg::ST_MATCH;
                        r.valid  = 1'b1;
                        r.last   = (k == hits);
                        awaited_results.push_back(r);
                    end
                end
                n_reported += hits;
            end
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: presents queued words, with random idle bursts.
    // ---------------------------------------------------------------
    colour_word_t cur_word;
    int           send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                tally_word(cur_word);
            // slot is free unless a word is still waiting for tready
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 11) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    s_tdata  <= {cur_word.alpha, cur_word.blue, cur_word.green,
                                 cur_word.red};
                    s_tuser  <= cur_word.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure and the field-by-field check.
    // ---------------------------------------------------------------
    int             stall_left = 0;
    colour_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing expected: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    failures++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("out_red",     int'(want.red),    int'(m_tdata[7:0]));
                    check_field("out_green",   int'(want.green),  int'(m_tdata[15:8]));
                    check_field("out_blue",    int'(want.blue),   int'(m_tdata[23:16]));
                    check_field("out_alpha",   int'(want.alpha),  int'(m_tdata[31:24]));
                    check_field("occurrences", int'(want.occ),    int'(m_tdata[47:32]));
                    check_field("status",      int'(want.status), int'(m_tuser[1:0]));
                    check_field("entry_valid", int'(want.valid),  int'(m_tuser[2]));
                    check_field("last",        int'(want.last),   int'(m_tlast));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void queue_add(input logic [31:0] key);
        colour_word_t w;
        w.kind = dcc_pkg::KIND_ADD;
        {w.red, w.green, w.blue, w.alpha} = key;
        pending_words.push_back(w);
    endfunction

    // colour fields of a report are don't-care, so fill them at random
    function automatic void queue_report();
        colour_word_t w;
        w.kind = dcc_pkg::KIND_REPORT;
        {w.red, w.green, w.blue, w.alpha} = $urandom;
        pending_words.push_back(w);
    endfunction

    // Wait until every word is sent and answered, then let the scan settle.
    task automatic drain();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Threshold write; only called with the block idle.
    task automatic set_threshold(input logic [dcc_pkg::COUNT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        report_min = value;
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int roll;

        for (int i = 0; i < PALETTE_N; i++)
            palette[i] = $urandom;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset threshold: empty report, extreme
        // colours, a repeat, and near misses differing in one channel.
        queue_report();
        queue_add(32'h0000_0000);
        queue_add(32'hFFFF_FFFF);
        queue_add(32'h0000_0000);
        queue_add(32'hFF00_0000);
        queue_add(32'h0000_00FF);
        queue_add(32'h00FF_0000);
        queue_add(32'h0000_FF00);
        queue_report();
        drain();

        // Repeats of black at full speed; a maximum threshold empties the report.
        set_threshold(dcc_pkg::COUNT_MAX);
        quiet = 1'b1;
        for (int i = 0; i < 8; i++)
            queue_add(32'h0000_0000);
        queue_report();
        queue_add(32'hFFFF_FFFF);
        drain();
        quiet = 1'b0;

        // Threshold zero lists every filled entry; one lists them too.
        set_threshold('0);
        queue_report();
        queue_add(32'h0000_0000);
        drain();
        set_threshold(dcc_pkg::COUNT_ONE);
        queue_report();
        drain();

        // Random part: a recurring palette builds counts, fresh colours fill
        // the table until it overflows. The last stretch runs without idling.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_threshold(dcc_pkg::THRESHOLD_RST);
                1: set_threshold(dcc_pkg::COUNT_W'($urandom_range(2, 6)));
                2: set_threshold(dcc_pkg::COUNT_W'(3));
                default: set_threshold(dcc_pkg::COUNT_ONE);
            endcase
            if (p == 3) quiet = 1'b1;
            for (int n = 0; n < 52; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    queue_report();
                else if (roll < 65)
                    queue_add(palette[$urandom_range(0, PALETTE_N - 1)]);
                else
                    queue_add($urandom);
            end
            drain();
        end

        $display("Adds: %0d matched (%0d at saturation), %0d inserted, %0d dropped on full",
                 n_matched, n_saturated, n_inserted, n_dropped);
        $display("Reports: %0d, %0d empty, %0d entries listed; table holds %0d",
                 n_reports, n_empty_reports, n_reported, shadow_filled);
        if (failures == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dcc_pkg.sv
rtl/core/dcc_ram.sv
rtl/core/dcc_ctrl.sv
rtl/core/dcc_dp.sv
rtl/core/distinct_color_counter.sv
rtl/core/dcc_checker.sv
test/tb_top.sv
